>>> hw/rtl/cmt_pkg.sv
// Shared types and constants for the code range mapping table.
`default_nettype none
package cmt_pkg;

  localparam int MAX_CELLS_DEF = 256;
  localparam int MAP_WORDS_DEF = 8192;
  localparam logic [15:0] NO_MAPPING_CODE_DEF = 16'hFFFD;

  localparam int CODE_W = 16;
  localparam int SLOT_W = 13;
  localparam int FMT_W  = 4;
  localparam int CNT_W  = 9;
  localparam int VAL_W  = 17;

  localparam logic [1:0] OP_WR_CELL = 2'd0;
  localparam logic [1:0] OP_WR_WORD = 2'd1;
  localparam logic [1:0] OP_LOOKUP  = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  localparam logic [FMT_W-1:0] FMT_OFFSET  = 4'd0;
  localparam logic [FMT_W-1:0] FMT_INDEXED = 4'd1;
  localparam logic [FMT_W-1:0] FMT_SINGLE  = 4'd2;

  // Lookup token passed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic              hit;
    logic              indexed;
    logic [VAL_W-1:0]  value;   // mapped code, or word address when indexed
  } link_t;

  // Cell write broadcast to the whole row.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [FMT_W-1:0]  format;
    logic [CODE_W-1:0] first;
    logic [CODE_W-1:0] last;
    logic [CODE_W-1:0] target;
  } cell_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FETCH,
    ST_DONE
  } st_t;

endpackage
`default_nettype wire

>>> hw/rtl/cmt_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module cmt_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/cmt_cell.sv
// One mapping cell: holds one range entry and checks the passing lookup token.
`default_nettype none
module cmt_cell #(
  parameter int CELL_ID = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cmt_pkg::cell_wr_t         wr,
  input  wire logic [cmt_pkg::CNT_W-1:0] cells_in_use,
  input  wire cmt_pkg::link_t            link_in,
  output cmt_pkg::link_t                 link_out
);

  localparam logic [cmt_pkg::SLOT_W-1:0] ID = cmt_pkg::SLOT_W'(CELL_ID);

  logic [cmt_pkg::FMT_W-1:0]  fmt;
  logic [cmt_pkg::CODE_W-1:0] first;
  logic [cmt_pkg::CODE_W-1:0] last;
  logic [cmt_pkg::CODE_W-1:0] target;

  logic                       active;
  logic                       match;
  logic [cmt_pkg::CODE_W-1:0] delta;
  logic [cmt_pkg::VAL_W-1:0]  value;
  logic                       take;

  always_ff @(posedge clk) begin
    if (wr.en && wr.slot == ID) begin
      fmt    <= wr.format;
      first  <= wr.first;
      last   <= wr.last;
      target <= wr.target;
    end
  end

  assign active = {{(cmt_pkg::SLOT_W-cmt_pkg::CNT_W){1'b0}}, cells_in_use} > ID;
  assign delta  = link_in.code - first;

  always_comb begin
    match = 1'b0;
    value = {1'b0, target};
    unique case (fmt)
      cmt_pkg::FMT_OFFSET: begin
        match = link_in.code >= first && link_in.code <= last;
        value = {1'b0, delta + target};
      end
      cmt_pkg::FMT_INDEXED: begin
        match = link_in.code >= first && link_in.code <= last;
        value = {1'b0, target} + {1'b0, delta};
      end
      cmt_pkg::FMT_SINGLE: begin
        match = link_in.code == first;
      end
      default: begin
        match = 1'b0;
      end
    endcase
  end

  // First hit along the row wins; later cells just forward.
  assign take = link_in.valid && !link_in.hit && active && match;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.valid <= 1'b0;
    end else begin
      link_out.valid <= link_in.valid;
    end
    link_out.code <= link_in.code;
    if (take) begin
      link_out.hit     <= 1'b1;
      link_out.indexed <= fmt == cmt_pkg::FMT_INDEXED;
      link_out.value   <= value;
    end else begin
      link_out.hit     <= link_in.hit;
      link_out.indexed <= link_in.indexed;
      link_out.value   <= link_in.value;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/code_range_mapping_table.sv
// Top level of the code range mapping table: cell row, mapping word RAM, control.
//
//  channel | direction | handshake           | contents
//  cfg     | in        | cfg_valid/cfg_ready | cells_in_use
//  s       | in        | s_tvalid/s_tready   | opcode in tuser, cell/word/lookup fields in tdata
//  m       | out       | m_tvalid/m_tready   | mapped_code in tdata, found in tuser
//
// A lookup walks the row of MAX_CELLS cells, one cell per cycle, then reads the
// mapping word RAM in the fetch state; write and no-op items go straight to done.
// Items are taken only when idle, so a new item waits until the last is loaded out.
// Reset is synchronous; the cell contents and the RAM are not cleared.
// A stalled output holds its result while the next item is already accepted.
`default_nettype none
module code_range_mapping_table #(
  parameter int          MAX_CELLS       = cmt_pkg::MAX_CELLS_DEF,
  parameter int          MAP_WORDS       = cmt_pkg::MAP_WORDS_DEF,
  parameter logic [15:0] NO_MAPPING_CODE = cmt_pkg::NO_MAPPING_CODE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data,    // cells_in_use
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // slot_index[12:0] cell_format[16:13] range_first[32:17] range_last[48:33]
  // target_value[64:49] lookup_code[80:65] zero[87:81]
  input  wire logic [87:0] s_tdata,
  input  wire logic [1:0]  s_tuser,     // opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,     // mapped_code
  output logic [0:0]       m_tuser      // found
);

  localparam int AW = $clog2(MAP_WORDS);
  localparam logic [cmt_pkg::VAL_W-1:0] WORDS = cmt_pkg::VAL_W'(MAP_WORDS);

  cmt_pkg::st_t state, state_next;

  logic [cmt_pkg::CNT_W-1:0]  cells_in_use;
  logic [cmt_pkg::SLOT_W-1:0] in_slot;
  logic [cmt_pkg::FMT_W-1:0]  in_fmt;
  logic [cmt_pkg::CODE_W-1:0] in_first;
  logic [cmt_pkg::CODE_W-1:0] in_last;
  logic [cmt_pkg::CODE_W-1:0] in_target;
  logic [cmt_pkg::CODE_W-1:0] in_code;
  logic [cmt_pkg::VAL_W-1:0]  slot_ext;

  logic accept;
  logic is_lookup;
  logic out_free;
  logic load_out;

  cmt_pkg::cell_wr_t cell_wr;
  cmt_pkg::link_t    head;
  cmt_pkg::link_t    links [MAX_CELLS];
  cmt_pkg::link_t    tail;
  logic [MAX_CELLS-1:0] chain_valid;

  logic                       word_wr;
  logic                       rd_en;
  logic [cmt_pkg::CODE_W-1:0] rd_data;

  logic                       hold_hit;
  logic                       hold_indexed;
  logic                       hold_inrange;
  logic [cmt_pkg::CODE_W-1:0] hold_value;
  logic [cmt_pkg::CODE_W-1:0] lk_mapped;

  logic [cmt_pkg::CODE_W-1:0] res_code;
  logic                       res_found;

  assign in_slot   = s_tdata[12:0];
  assign in_fmt    = s_tdata[16:13];
  assign in_first  = s_tdata[32:17];
  assign in_last   = s_tdata[48:33];
  assign in_target = s_tdata[64:49];
  assign in_code   = s_tdata[80:65];
  assign slot_ext  = {{(cmt_pkg::VAL_W-cmt_pkg::SLOT_W){1'b0}}, in_slot};

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_in_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cells_in_use <= cfg_data;
    end
  end

  assign accept    = s_tvalid && s_tready;
  assign is_lookup = s_tuser == cmt_pkg::OP_LOOKUP;
  assign out_free  = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cmt_pkg::ST_IDLE:  if (accept) state_next = is_lookup ? cmt_pkg::ST_WALK
                                                            : cmt_pkg::ST_DONE;
      cmt_pkg::ST_WALK:  if (tail.valid) state_next = cmt_pkg::ST_FETCH;
      cmt_pkg::ST_FETCH: state_next = cmt_pkg::ST_DONE;
      cmt_pkg::ST_DONE:  if (out_free) state_next = cmt_pkg::ST_IDLE;
      default:           state_next = cmt_pkg::ST_IDLE;
    endcase
  end

  // outputs of the control
  always_comb begin
    s_tready = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    unique case (state)
      cmt_pkg::ST_IDLE:  s_tready = 1'b1;
      cmt_pkg::ST_WALK:  rd_en    = tail.valid;
      cmt_pkg::ST_FETCH: ;
      cmt_pkg::ST_DONE:  load_out = out_free;
      default:           ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // cell row
  assign cell_wr.en     = accept && s_tuser == cmt_pkg::OP_WR_CELL;
  assign cell_wr.slot   = in_slot;
  assign cell_wr.format = in_fmt;
  assign cell_wr.first  = in_first;
  assign cell_wr.last   = in_last;
  assign cell_wr.target = in_target;

  assign head.valid   = accept && is_lookup;
  assign head.code    = in_code;
  assign head.hit     = 1'b0;
  assign head.indexed = 1'b0;
  assign head.value   = '0;

  for (genvar k = 0; k < MAX_CELLS; k++) begin : g_cell
    if (k == 0) begin : g_first
      cmt_cell #(.CELL_ID(k)) u_cell (
        .clk          (clk),
        .rst          (rst),
        .wr           (cell_wr),
        .cells_in_use (cells_in_use),
        .link_in      (head),
        .link_out     (links[k])
      );
    end else begin : g_next
      cmt_cell #(.CELL_ID(k)) u_cell (
        .clk          (clk),
        .rst          (rst),
        .wr           (cell_wr),
        .cells_in_use (cells_in_use),
        .link_in      (links[k-1]),
        .link_out     (links[k])
      );
    end
    assign chain_valid[k] = links[k].valid;
  end

  assign tail = links[MAX_CELLS-1];

  // mapping words
  assign word_wr = accept && s_tuser == cmt_pkg::OP_WR_WORD && slot_ext < WORDS;

  cmt_ram #(
    .WIDTH (cmt_pkg::CODE_W),
    .DEPTH (MAP_WORDS)
  ) u_words (
    .clk     (clk),
    .wr_en   (word_wr),
    .wr_addr (slot_ext[AW-1:0]),
    .wr_data (in_target),
    .rd_en   (rd_en),
    .rd_addr (tail.value[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rd_en) begin
      hold_hit     <= tail.hit;
      hold_indexed <= tail.indexed;
      hold_inrange <= tail.value < WORDS;
      hold_value   <= tail.value[cmt_pkg::CODE_W-1:0];
    end
  end

  always_comb begin
    if (!hold_hit) begin
      lk_mapped = NO_MAPPING_CODE;
    end else if (hold_indexed) begin
      lk_mapped = hold_inrange ? rd_data : NO_MAPPING_CODE;
    end else begin
      lk_mapped = hold_value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_lookup) begin
      res_code  <= '0;
      res_found <= 1'b0;
    end else if (state == cmt_pkg::ST_FETCH) begin
      res_code  <= lk_mapped;
      res_found <= hold_hit && lk_mapped != NO_MAPPING_CODE;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata    <= res_code;
      m_tuser[0] <= res_found;
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(chain_valid) <= 1)
    else $error("more than one lookup in the cell row");

  a_tail_in_walk: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> state == cmt_pkg::ST_WALK)
    else $error("lookup left the row outside the walk state");

  a_fetch_after_tail: assert property (@(posedge clk) disable iff (rst)
    state == cmt_pkg::ST_FETCH |-> $past(tail.valid))
    else $error("fetch without a finished walk");

  a_write_done: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_lookup) |=> state == cmt_pkg::ST_DONE)
    else $error("write item did not finish at once");

  a_found_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tdata == NO_MAPPING_CODE))
    else $error("found set with the no-mapping code");

endmodule
`default_nettype wire
